[sv/ldrb_pkg.sv]
// shared types, codes and constants for the led dimmer ramp and breathe block
package ldrb_pkg;

   // request kinds
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_DEADBAND    = 2'd0;
   localparam logic [1:0] CSR_FADE_TOP    = 2'd1;
   localparam logic [1:0] CSR_FADE_PERIOD = 2'd2;
   localparam logic [1:0] CSR_RAMP_PERIOD = 2'd3;

   // register reset values
   localparam logic [7:0] DEADBAND_RST    = 8'd5;
   localparam logic [7:0] FADE_TOP_RST    = 8'd150;
   localparam logic [7:0] FADE_PERIOD_RST = 8'd12;
   localparam logic [7:0] RAMP_PERIOD_RST = 8'd1;

   // pulse width mapping: (w - 1075) * 250 / 825 = (w - 1075) * 10 / 33
   localparam logic signed [12:0] PULSE_OFFSET = 13'sd1075;
   localparam logic [3:0]         MAP_NUM      = 4'd10;
   // floor(x / 33) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 2^15
   localparam int                 RECIP_SHIFT  = 21;
   localparam logic [15:0]        RECIP_MUL    = 16'd63551;
   localparam logic signed [10:0] MAP_MAX      = 11'sd250;

   localparam logic [7:0] LEVEL_MAX = 8'hFF;
   localparam logic [7:0] LEVEL_MIN = 8'h00;

   // operating mode
   typedef enum logic [1:0] {
      MODE_STEADY = 2'b01,
      MODE_FADE   = 2'b10
   } mode_type;

   typedef struct packed {
      logic [7:0] deadband;
      logic [7:0] fade_top;
      logic [7:0] fade_period;
      logic [7:0] ramp_period;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic [11:0] channel_us;
   } req_item_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       duty_written;
      logic       fade_mode;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  level;
      logic [7:0]  request;
      mode_type    mode;
      logic        rising;
      logic [31:0] last_step_ms;
   } state_type;

endpackage

[sv/ldrb_ifs.sv]
// request, response and register write channel interfaces
interface ldrb_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] now_ms;
   logic [11:0] channel_us;

   modport source (output valid, output func, output now_ms, output channel_us, input ready);
   modport sink (input valid, input func, input now_ms, input channel_us, output ready);
endinterface

interface ldrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] duty;
   logic       duty_written;
   logic       fade_mode;

   modport source (output valid, output duty, output duty_written, output fade_mode,
                   input ready);
   modport sink (input valid, input duty, input duty_written, input fade_mode,
                 output ready);
endinterface

interface ldrb_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/led_dimmer_ramp_and_breathe.sv]
// top level of the led dimmer with ramp toward request and breathing fade
// Takes one request per clock while responses are taken, and returns one
// response per request, in order. A request is captured in an input
// register; once the response register is free or being emptied, the
// single-pass step logic reads the dimmer state, updates it, and loads the
// response register. Throughput is one request per cycle while responses
// are taken; the response register lets a request in while a response waits.
// Register writes are taken at any time and should be made while idle.
module led_dimmer_ramp_and_breathe (
   input  logic      clock,
   input  logic      reset,
   ldrb_req_if.sink  req,
   ldrb_rsp_if.source rsp,
   ldrb_csr_if.sink  csr
);
   import ldrb_pkg::*;

   cfg_type      cfg;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_res_ff;
   state_type    st_ff;
   state_type    st_next;
   rsp_item_type res;
   logic         advance;
   logic         req_fire;

   ldrb_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   ldrb_step u_step (
      .item    (s1_item_ff),
      .st      (st_ff),
      .cfg     (cfg),
      .st_next (st_next),
      .res     (res)
   );

   // handshake
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !s1_valid_ff || advance;
   assign req_fire     = req.valid && req.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   // control and dimmer state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         st_ff.level        <= 8'd0;
         st_ff.request      <= 8'd0;
         st_ff.mode         <= MODE_STEADY;
         st_ff.rising       <= 1'b0;
         st_ff.last_step_ms <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) st_ff <= st_next;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.func       <= req.func;
         s1_item_ff.now_ms     <= req.now_ms;
         s1_item_ff.channel_us <= req.channel_us;
      end
      if (advance) out_res_ff <= res;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.duty         = out_res_ff.duty;
   assign rsp.duty_written = out_res_ff.duty_written;
   assign rsp.fade_mode    = out_res_ff.fade_mode;

`ifndef SYNTHESIS
   // input stalls only when both stages hold an unaccepted request
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && out_valid_ff && !rsp.ready))
      else $error("input stalled with a free stage");

   // a response that reports no write leaves the level where it was
   a_no_write_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !res.duty_written) |=> (st_ff.level == $past(st_ff.level)))
      else $error("level changed without a write");

   // a steady-mode write moves the level one step
   a_steady_step: assert property (@(posedge clock) disable iff (reset)
      (advance && res.duty_written && st_ff.mode == MODE_STEADY) |=>
      (st_ff.level == $past(st_ff.level) + 8'd1 || st_ff.level == $past(st_ff.level) - 8'd1))
      else $error("steady ramp step not one level");

   // a response is loaded only when the input stage held a request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff)) |-> $past(s1_valid_ff))
      else $error("response without request");
`endif
endmodule

[sv/ldrb_map.sv]
// maps a channel pulse width to a signed request value, truncated toward zero
module ldrb_map (
   input  logic [11:0]        channel_us,
   output logic signed [10:0] mapped
);
   import ldrb_pkg::*;

   logic signed [12:0] offset_val;
   logic               neg;
   logic [11:0]        mag;
   logic [14:0]        scaled;
   logic [30:0]        full;
   logic [9:0]         quot;

   // offset and magnitude
   assign offset_val = $signed({1'b0, channel_us}) - PULSE_OFFSET;
   assign neg        = offset_val[12];
   assign mag        = neg ? 12'(-offset_val) : 12'(offset_val);

   // scale by 10 and divide by 33 through the reciprocal
   assign scaled = 15'(mag) * 15'(MAP_NUM);
   assign full   = 31'(scaled) * 31'(RECIP_MUL);
   assign quot   = full[RECIP_SHIFT +: 10];

   // restore sign
   assign mapped = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
endmodule

[sv/ldrb_step.sv]
// next state and response for one request, from the current state
module ldrb_step (
   input  ldrb_pkg::req_item_type item,
   input  ldrb_pkg::state_type    st,
   input  ldrb_pkg::cfg_type      cfg,
   output ldrb_pkg::state_type    st_next,
   output ldrb_pkg::rsp_item_type res
);
   import ldrb_pkg::*;

   logic signed [10:0] mapped;
   logic signed [11:0] diff;
   logic [11:0]        diff_mag;
   logic               in_range;
   logic [31:0]        elapsed;
   logic               fade_due;
   logic               ramp_due;
   logic               rise_now;
   logic               written;

   ldrb_map u_map (
      .channel_us (item.channel_us),
      .mapped     (mapped)
   );

   // deadband distance on the unclamped value
   assign diff     = $signed({4'b0000, st.request}) - $signed({mapped[10], mapped});
   assign diff_mag = diff[11] ? 12'(-diff) : 12'(diff);
   assign in_range = mapped <= MAP_MAX;

   // step timing
   assign elapsed  = item.now_ms - st.last_step_ms;
   assign fade_due = elapsed >= {24'd0, cfg.fade_period};
   assign ramp_due = elapsed >= {24'd0, cfg.ramp_period};

   // fade direction, bottom check first and top check wins
   always_comb begin
      rise_now = st.rising;
      if (st.level == LEVEL_MIN) rise_now = 1'b1;
      if (st.level > cfg.fade_top) rise_now = 1'b0;
   end

   always_comb begin
      st_next = st;
      written = 1'b0;
      if (item.func == FUNC_UPDATE) begin
         // channel update
         if (in_range && (st.mode == MODE_FADE || diff_mag > {4'd0, cfg.deadband})) begin
            st_next.mode    = MODE_STEADY;
            st_next.request = mapped[10] ? 8'd0 : mapped[7:0];
         end
         if (!in_range) st_next.mode = MODE_FADE;
      end else begin
         // time tick
         unique case (st.mode)
            MODE_FADE: begin
               st_next.rising = rise_now;
               if (fade_due) begin
                  written              = 1'b1;
                  st_next.last_step_ms = item.now_ms;
                  if (rise_now) begin
                     st_next.level = (st.level == LEVEL_MAX) ? st.level : st.level + 8'd1;
                  end else begin
                     st_next.level = (st.level == LEVEL_MIN) ? st.level : st.level - 8'd1;
                  end
               end
            end
            MODE_STEADY: begin
               if (st.level != st.request && ramp_due) begin
                  written              = 1'b1;
                  st_next.last_step_ms = item.now_ms;
                  st_next.level = (st.level < st.request) ? st.level + 8'd1
                                                          : st.level - 8'd1;
               end
            end
            default: ;
         endcase
      end
   end

   assign res.duty         = st_next.level;
   assign res.duty_written = written;
   assign res.fade_mode    = (st_next.mode == MODE_FADE);
endmodule

[sv/ldrb_csr.sv]
// configuration registers with their write port
module ldrb_csr (
   input  logic              clock,
   input  logic              reset,
   ldrb_csr_if.sink          csr,
   output ldrb_pkg::cfg_type cfg
);
   import ldrb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_DEADBAND:    cfg_in.deadband    = csr.data;
            CSR_FADE_TOP:    cfg_in.fade_top    = csr.data;
            CSR_FADE_PERIOD: cfg_in.fade_period = csr.data;
            CSR_RAMP_PERIOD: cfg_in.ramp_period = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband    <= DEADBAND_RST;
         cfg_ff.fade_top    <= FADE_TOP_RST;
         cfg_ff.fade_period <= FADE_PERIOD_RST;
         cfg_ff.ramp_period <= RAMP_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[tb/ldrb_duty_checker.sv]
// response checker with a duty level predictor for the led dimmer
`timescale 1ns / 100ps

module ldrb_duty_checker (
   input  logic clock,
   input  logic reset,
   ldrb_req_if  req,
   ldrb_rsp_if  rsp,
   ldrb_csr_if  csr,
   output int   mismatches,
   output int   awaited
);
   import ldrb_pkg::*;

   // pulse width to request mapping
   localparam int PULSE_LOW = 1075;
   localparam int MAP_SPAN  = 825;
   localparam int MAP_TOP   = 250;
   localparam int REPORT_MAX = 10;

   // register copies
   logic [7:0] deadband_r;
   logic [7:0] fade_top_r;
   logic [7:0] fade_per_r;
   logic [7:0] ramp_per_r;

   // dimmer state copy
   logic [7:0]  level;
   logic [7:0]  target;
   logic        fading;
   logic        rising;
   logic [31:0] last_ms;

   // responses still owed by the block, oldest first
   rsp_item_type duty_due[$];

   // one step of the level toward limit once the period has passed
   function automatic logic take_step(input logic [31:0] now, input logic [7:0] period,
                                      input logic up, input logic [7:0] limit);
      int v;
      if ((now - last_ms) < {24'd0, period})
         return 1'b0;
      last_ms = now;
      v = up ? int'(level) + 1 : int'(level) - 1;
      if (up && v > int'(limit))
         v = int'(limit);
      if (!up && v < int'(limit))
         v = int'(limit);
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      level = v[7:0];
      return 1'b1;
   endfunction

   // next dimmer state and the response one request yields
   function automatic rsp_item_type dimmer_next(input req_item_type r);
      rsp_item_type o;
      int val;
      int diff;
      logic wr;
      wr = 1'b0;
      if (r.func == FUNC_UPDATE) begin
         // truncating division, deadband judged on the unclamped value
         val = ((int'(r.channel_us) - PULSE_LOW) * MAP_TOP) / MAP_SPAN;
         diff = int'(target) - val;
         if (diff < 0)
            diff = -diff;
         if (val <= MAP_TOP && (fading || diff > int'(deadband_r))) begin
            fading = 1'b0;
            target = (val < 0) ? 8'd0 : val[7:0];
         end
         if (val > MAP_TOP)
            fading = 1'b1;
      end else if (fading) begin
         // breathing: turn up at the bottom, turn down above the top
         if (level < 8'd1)
            rising = 1'b1;
         if (level > fade_top_r)
            rising = 1'b0;
         wr = take_step(r.now_ms, fade_per_r, rising, rising ? LEVEL_MAX : LEVEL_MIN);
      end else if (level > target) begin
         wr = take_step(r.now_ms, ramp_per_r, 1'b0, target);
      end else if (level < target) begin
         wr = take_step(r.now_ms, ramp_per_r, 1'b1, target);
      end
      o.duty = level;
      o.duty_written = wr;
      o.fade_mode = fading;
      return o;
   endfunction

   // watch the three channels at each edge
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      req_item_type seen;
      if (reset) begin
         deadband_r = DEADBAND_RST;
         fade_top_r = FADE_TOP_RST;
         fade_per_r = FADE_PERIOD_RST;
         ramp_per_r = RAMP_PERIOD_RST;
         level = 8'd0;
         target = 8'd0;
         fading = 1'b0;
         rising = 1'b0;
         last_ms = 32'd0;
         duty_due.delete();
         mismatches = 0;
         awaited <= 0;
      end else begin
         // register writes
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_DEADBAND:    deadband_r = csr.data;
               CSR_FADE_TOP:    fade_top_r = csr.data;
               CSR_FADE_PERIOD: fade_per_r = csr.data;
               CSR_RAMP_PERIOD: ramp_per_r = csr.data;
               default: ;
            endcase
         end
         // compare a response with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got = '{duty: rsp.duty, duty_written: rsp.duty_written, fade_mode: rsp.fade_mode};
            if (duty_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("response with no request pending: duty=%0d written=%0b fade=%0b",
                           got.duty, got.duty_written, got.fade_mode);
            end else begin
               want = duty_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch: expected duty=%0d written=%0b fade=%0b, %s%0d %s%0b %s%0b",
                              want.duty, want.duty_written, want.fade_mode,
                              "got duty=", got.duty, "written=", got.duty_written,
                              "fade=", got.fade_mode);
               end
            end
         end
         // predict the response of an accepted request
         if (req.valid && req.ready) begin
            seen.func = req.func;
            seen.now_ms = req.now_ms;
            seen.channel_us = req.channel_us;
            duty_due.push_back(dimmer_next(seen));
         end
         awaited <= duty_due.size();
      end
   end

endmodule

[tb/tb_led_dimmer_ramp_and_breathe.sv]
// stimulus and verdict for the led dimmer ramp and breathe block
`timescale 1ns / 100ps

module tb_led_dimmer_ramp_and_breathe;
   import ldrb_pkg::*;

   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 150;
   localparam int BURST_ITEMS = 30;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ldrb_req_if req_ch ();
   ldrb_rsp_if rsp_ch ();
   ldrb_csr_if csr_ch ();

   int mismatches;
   int awaited;

   // stimulus shaping
   logic [31:0] tick_ms;
   logic [7:0]  cur_fp;
   logic [7:0]  cur_rp;
   int          upd_pct;
   int          fade_bias;
   bit          no_idle;
   int          hold_asks;

   led_dimmer_ramp_and_breathe i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   ldrb_duty_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one request after a random gap and wait for its acceptance
   task automatic send_req(input logic func, input logic [31:0] now, input logic [11:0] us);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.now_ms <= now;
      req_ch.channel_us <= us;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // one random request: mostly ticks with advancing time, some pulse updates
   task automatic send_random();
      int pick;
      int span;
      logic [11:0] us;
      pick = $urandom_range(0, 99);
      if (pick < upd_pct) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            us = 12'($urandom_range(0, 4095));
         else if (pick < 16)
            us = 12'($urandom_range(1895, 1910));
         else if ($urandom_range(0, 99) < fade_bias)
            us = 12'($urandom_range(1904, 2300));
         else
            us = 12'($urandom_range(1000, 1903));
         send_req(FUNC_UPDATE, $urandom, us);
      end else begin
         pick = $urandom_range(0, 99);
         span = ((cur_fp > cur_rp) ? int'(cur_fp) : int'(cur_rp)) + 2;
         if (pick < 3)
            tick_ms = $urandom;
         else if (pick < 5)
            tick_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
         else
            tick_ms = tick_ms + $urandom_range(0, span);
         send_req(FUNC_TICK, tick_ms, 12'($urandom_range(0, 4095)));
      end
   endtask

   // stop offering and let every owed response come back
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic write_config(input logic [7:0] db, input logic [7:0] ft,
                               input logic [7:0] fp, input logic [7:0] rp);
      logic [1:0] reg_idx [4];
      logic [7:0] reg_val [4];
      reg_idx = '{CSR_DEADBAND, CSR_FADE_TOP, CSR_FADE_PERIOD, CSR_RAMP_PERIOD};
      reg_val = '{db, ft, fp, rp};
      for (int k = 0; k < 4; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= reg_idx[k];
         csr_ch.data <= reg_val[k];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      cur_fp = fp;
      cur_rp = rp;
   endtask

   // response side: random ready gaps plus an occasional long hold
   initial begin
      int gap;
      int hold_done;
      hold_done = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asks != hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = hold_asks;
         end
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // main sequence
   initial begin
      logic [7:0] db;
      logic [7:0] ft;
      logic [7:0] fp;
      logic [7:0] rp;
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_TICK;
      req_ch.now_ms <= 32'd0;
      req_ch.channel_us <= 12'd0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_DEADBAND;
      csr_ch.data <= 8'd0;
      tick_ms = 32'd0;
      cur_fp = FADE_PERIOD_RST;
      cur_rp = RAMP_PERIOD_RST;
      upd_pct = 20;
      fade_bias = 50;
      no_idle = 1'b0;
      hold_asks = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset register values
      send_req(FUNC_TICK, 32'd0, 12'd0);            // level equals request
      send_req(FUNC_UPDATE, 32'hFFFF_FFFF, 12'd0);  // lowest width, clamped to zero
      send_req(FUNC_UPDATE, 32'd0, 12'd1900);       // top of the steady range
      send_req(FUNC_TICK, 32'd1, 12'hFFF);
      send_req(FUNC_TICK, 32'd2, 12'd0);
      send_req(FUNC_TICK, 32'd2, 12'd0);            // period not yet passed
      send_req(FUNC_UPDATE, 32'd0, 12'd1076);
      send_req(FUNC_UPDATE, 32'd0, 12'd1093);       // change equal to deadband, ignored
      send_req(FUNC_UPDATE, 32'd0, 12'd1097);       // just past the deadband
      send_req(FUNC_TICK, 32'd3, 12'd0);
      send_req(FUNC_UPDATE, 32'd0, 12'd4095);       // highest width enters fade
      send_req(FUNC_UPDATE, 32'd0, 12'd1904);       // just above the steady range
      send_req(FUNC_TICK, 32'd20, 12'd0);
      send_req(FUNC_TICK, 32'd25, 12'd0);
      send_req(FUNC_TICK, 32'd32, 12'd0);
      send_req(FUNC_UPDATE, 32'd0, 12'd1097);       // leaving fade ignores the deadband
      send_req(FUNC_UPDATE, 32'd0, 12'd2000);
      send_req(FUNC_TICK, 32'hFFFF_FFFF, 12'd0);
      send_req(FUNC_TICK, 32'h0000_000A, 12'd0);    // time wrap, not due
      send_req(FUNC_TICK, 32'h0000_000B, 12'd0);    // time wrap, due
      send_req(FUNC_UPDATE, 32'd0, 12'd1903);
      send_req(FUNC_UPDATE, 32'd0, 12'd1000);       // negative value truncates toward zero
      send_req(FUNC_TICK, 32'h7FFF_FFFF, 12'd0);
      send_req(FUNC_TICK, 32'h8000_0000, 12'd0);
      wait_drain();

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               db = 8'd0;   ft = 8'd0;   fp = 8'd0;   rp = 8'd0;
            end
            1: begin
               db = 8'd250; ft = 8'd254; fp = 8'd255; rp = 8'd255;
            end
            2: begin
               db = DEADBAND_RST; ft = FADE_TOP_RST; fp = FADE_PERIOD_RST; rp = RAMP_PERIOD_RST;
            end
            default: begin
               db = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 250)
                                                   : $urandom_range(0, 12));
               ft = 8'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 254)
                                                   : $urandom_range(0, 40));
               fp = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 6));
               rp = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 4));
            end
         endcase
         write_config(db, ft, fp, rp);
         tick_ms = $urandom;
         upd_pct = $urandom_range(3, 30);
         fade_bias = $urandom_range(0, 100);

         // long response hold while requests keep coming
         if (phase % 3 == 0) begin
            hold_asks++;
            no_idle = 1'b1;
            repeat (BURST_ITEMS) send_random();
            no_idle = 1'b0;
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0)
               no_idle = !no_idle;
            send_random();
         end
         no_idle = 1'b0;
         wait_drain();
      end

      // verdict
      if (mismatches == 0 && awaited == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
